/* hdl/tfc_pkg.sv */
package tfc_pkg;

    localparam int FRAME_LENGTH = 12;
    localparam int POS_W        = $clog2(FRAME_LENGTH);
    localparam int POS_EXT_W    = 8;

    localparam int BYTE_W       = 8;
    localparam int CRC_W        = 16;
    localparam int STATUS_W     = 2;
    localparam int VOLT_W       = 11;
    localparam int TEMP_W       = 14;

    localparam int VALUE_BYTES  = 6;
    localparam int FIRST_VALUE  = 4;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    localparam logic [VOLT_W-1:0] VOLT_OFFSET = 11'd850;
    localparam logic [TEMP_W-1:0] TEMP_SCALE  = 14'd36;

    localparam logic [STATUS_W-1:0] ST_VALID  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HEADER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CRC    = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE   = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] destination;
        logic [BYTE_W-1:0] source;
        logic [BYTE_W-1:0] msg_type;
    } t_cfg;

    typedef struct packed {
        logic [STATUS_W-1:0]                   status;
        logic [VALUE_BYTES-1:0][BYTE_W-1:0]    values;
    } t_frame;

    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* hdl/tfc_byte_if.sv */
interface tfc_byte_if;
    logic                       valid;
    logic                       ready;
    logic [tfc_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hdl/tfc_result_if.sv */
interface tfc_result_if;
    logic                         valid;
    logic                         ready;
    logic [tfc_pkg::STATUS_W-1:0] frame_status;
    logic [tfc_pkg::BYTE_W-1:0]   load_current_two;
    logic [tfc_pkg::BYTE_W-1:0]   load_current_one;
    logic [tfc_pkg::VOLT_W-1:0]   bus_voltage_two;
    logic [tfc_pkg::VOLT_W-1:0]   bus_voltage_one;
    logic [tfc_pkg::TEMP_W-1:0]   case_temp_two;
    logic [tfc_pkg::TEMP_W-1:0]   case_temp_one;

    modport source (output valid, output frame_status, output load_current_two,
                    output load_current_one, output bus_voltage_two,
                    output bus_voltage_one, output case_temp_two,
                    output case_temp_one, input ready);
    modport sink   (input valid, input frame_status, input load_current_two,
                    input load_current_one, input bus_voltage_two,
                    input bus_voltage_one, input case_temp_two,
                    input case_temp_one, output ready);
endinterface

/* hdl/tfc_front.sv */
module tfc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tfc_byte_if.sink        i_rx,
    input  tfc_pkg::t_cfg   i_cfg,
    input  logic            i_full,
    output logic            o_push,
    output tfc_pkg::t_frame o_frame
);
    import tfc_pkg::*;

    logic                                r_hunting;
    logic [POS_W-1:0]                    r_pos;
    logic [CRC_W-1:0]                    r_crc;
    logic                                r_header_good;
    logic [VALUE_BYTES-1:0][BYTE_W-1:0]  r_payload;
    logic [BYTE_W-1:0]                   r_crc_high;

    logic                  w_accept;
    logic                  w_last;
    logic                  w_body;
    logic                  w_crc_hi;
    logic [POS_EXT_W-1:0]  w_pos_ext;
    logic [CRC_W-1:0]      w_crc_next;
    logic [CRC_W-1:0]      w_got;
    logic [BYTE_W-1:0]     w_b;

    assign w_b        = i_rx.rx_byte;
    assign w_pos_ext  = POS_EXT_W'(r_pos);
    assign w_last     = !r_hunting && (w_pos_ext == POS_EXT_W'(FRAME_LENGTH - 1));
    assign w_crc_hi   = !r_hunting && (w_pos_ext == POS_EXT_W'(FRAME_LENGTH - 2));
    assign w_body     = !r_hunting && (w_pos_ext < POS_EXT_W'(FRAME_LENGTH - 2));
    // the only place a result is produced is the last byte, so stall only there
    assign i_rx.ready = !(w_last && i_full);
    assign w_accept   = i_rx.valid && i_rx.ready;
    assign w_crc_next = crc_feed(r_hunting ? CRC_INIT : r_crc, w_b);
    assign w_got      = {r_crc_high, w_b};

    assign o_push = w_accept && w_last;
    always_comb begin
        o_frame.values = r_payload;
        if (!r_header_good) begin
            o_frame.status = ST_HEADER;
        end else if (w_got != r_crc) begin
            o_frame.status = ST_CRC;
        end else begin
            o_frame.status = ST_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting     <= 1'b1;
            r_pos         <= '0;
            r_crc         <= CRC_INIT;
            r_header_good <= 1'b1;
        end else if (w_accept) begin
            if (r_hunting) begin
                if (w_b == i_cfg.start_marker) begin
                    r_hunting     <= 1'b0;
                    r_pos         <= POS_W'(1);
                    r_crc         <= w_crc_next;
                    r_header_good <= 1'b1;
                end
            end else if (w_body) begin
                r_crc <= w_crc_next;
                r_pos <= r_pos + POS_W'(1);
                if ((w_pos_ext == POS_EXT_W'(1) && w_b != i_cfg.destination) ||
                    (w_pos_ext == POS_EXT_W'(2) && w_b != i_cfg.source) ||
                    (w_pos_ext == POS_EXT_W'(3) && w_b != i_cfg.msg_type)) begin
                    r_header_good <= 1'b0;
                end
            end else if (w_crc_hi) begin
                r_pos <= r_pos + POS_W'(1);
            end else begin
                r_hunting     <= 1'b1;
                r_pos         <= '0;
                r_crc         <= CRC_INIT;
                r_header_good <= 1'b1;
            end
        end
    end

    // payload capture, cleared at each start byte
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (r_hunting && w_b == i_cfg.start_marker) begin
                r_payload  <= '0;
                r_crc_high <= '0;
            end else begin
                if (w_crc_hi) begin
                    r_crc_high <= w_b;
                end
                for (int i = 0; i < VALUE_BYTES; i++) begin
                    if (w_body && w_pos_ext == POS_EXT_W'(FIRST_VALUE + i)) begin
                        r_payload[i] <= w_b;
                    end
                end
            end
        end
    end

endmodule

/* hdl/tfc_queue.sv */
module tfc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tfc_pkg::t_frame i_frame,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output tfc_pkg::t_frame o_frame
);
    import tfc_pkg::*;

    t_frame              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    logic w_push;
    logic w_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_frame = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

/* hdl/tfc_back.sv */
module tfc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  tfc_pkg::t_frame i_frame,
    output logic            o_pop,
    tfc_result_if.source    o_res
);
    import tfc_pkg::*;

    logic                r_valid;
    logic [STATUS_W-1:0] r_status;
    logic [BYTE_W-1:0]   r_cur_two;
    logic [BYTE_W-1:0]   r_cur_one;
    logic [VOLT_W-1:0]   r_volt_two;
    logic [VOLT_W-1:0]   r_volt_one;
    logic [TEMP_W-1:0]   r_temp_two;
    logic [TEMP_W-1:0]   r_temp_one;

    logic                                w_good;
    logic [VALUE_BYTES-1:0][BYTE_W-1:0]  w_v;

    assign o_pop  = i_valid && (!r_valid || o_res.ready);
    assign w_good = (i_frame.status == ST_VALID);
    // failed frames report all values as zero
    assign w_v    = w_good ? i_frame.values : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status   <= i_frame.status;
            r_cur_two  <= w_v[0];
            r_cur_one  <= w_v[1];
            r_volt_two <= w_good ? VOLT_W'({w_v[2], 1'b0}) + VOLT_OFFSET : '0;
            r_volt_one <= w_good ? VOLT_W'({w_v[3], 1'b0}) + VOLT_OFFSET : '0;
            r_temp_two <= TEMP_W'(w_v[4]) * TEMP_SCALE;
            r_temp_one <= TEMP_W'(w_v[5]) * TEMP_SCALE;
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.frame_status     = r_status;
    assign o_res.load_current_two = r_cur_two;
    assign o_res.load_current_one = r_cur_one;
    assign o_res.bus_voltage_two  = r_volt_two;
    assign o_res.bus_voltage_one  = r_volt_one;
    assign o_res.case_temp_two    = r_temp_two;
    assign o_res.case_temp_one    = r_temp_one;

endmodule

/* hdl/telemetry_frame_checker_unit.sv */
// telemetry frame checker
// i_rx carries one received byte per transaction; the block hunts for the
// start marker, gathers a frame of FRAME_LENGTH bytes, checks the header
// bytes and the CRC-16 (poly 0x1021, init 0xFFFF) and sends one transaction
// on o_res per frame: a status plus six values, voltages and temperatures scaled (zero on failure).
// i_cfg_we/i_cfg_idx/i_cfg_data write the start marker, destination, source
// and message type registers; write only while no frame is in flight.
// throughput: one byte per cycle while i_rx.ready is high; the CRC advances a
// whole byte per accepted byte. a frame's result is written to the queue as its
// last byte is accepted, and then to the output register once it has room.
// a two-entry queue sits between the byte front end and the output stage;
// when o_res stalls, bytes still flow until a frame end finds the queue
// full, and then i_rx.ready drops on that last byte only.
// reset (synchronous, active low) returns to hunting, empties the queue and
// the output register and restores the register defaults.
module telemetry_frame_checker_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tfc_byte_if.sink                      i_rx,
    tfc_result_if.source                  o_res,
    input  logic                          i_cfg_we,
    input  logic [tfc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tfc_pkg::BYTE_W-1:0]    i_cfg_data
);
    import tfc_pkg::*;

    t_cfg   r_cfg;
    logic   w_push;
    logic   w_full;
    logic   w_q_valid;
    logic   w_pop;
    t_frame w_push_frame;
    t_frame w_pop_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= 8'hAA;
            r_cfg.destination  <= 8'd2;
            r_cfg.source       <= 8'd1;
            r_cfg.msg_type     <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START:  r_cfg.start_marker <= i_cfg_data;
                CFG_DEST:   r_cfg.destination  <= i_cfg_data;
                CFG_SOURCE: r_cfg.source       <= i_cfg_data;
                CFG_TYPE:   r_cfg.msg_type     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tfc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_cfg   (r_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_frame (w_push_frame)
    );

    tfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_frame (w_push_frame),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_frame (w_pop_frame)
    );

    tfc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_frame (w_pop_frame),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule
